>>> hw/rtl/ihd_pkg.sv
// ----------------------------------------------------------------------------
// ihd_pkg
// shared constants and codes for the indexed min-heap with decrease key
// ----------------------------------------------------------------------------
package ihd_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int MAX_HANDLES_DEF = 4096;
    localparam int VALUE_BITS_DEF  = 32;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_GET_MIN  = 2'd1,
        OP_EXTRACT  = 2'd2,
        OP_DECREASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_STALE = 2'd3
    } status_t;

endpackage

>>> hw/rtl/indexed_min_heap_decrease_key.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key
// binary min-heap with handles: insert, get minimum, extract minimum and
// decrease key, heap slots and handle map held in two synchronous memories
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with op, value, handle, delta; one
// transaction per operation. output channel: out_valid / out_stall with
// status, min_value, count, assigned_handle; one transaction per input.
// in_stall is high while an operation is in progress. an operation runs,
// from acceptance until the next input can be taken, through these steps:
//   get minimum, empty or full heap, handle zero or never issued: result only
//   handle already removed (found through the map): map read, then result
//   insert: parent read and compare per level, until the root or a compare stops
//   decrease key: map read, slot read, then the same sift up as insert
//   extract: root read, last entry read, result with one entry, else per level
//   left child read, right child read, compare, until a compare keeps it in place
// each sift level is a parent or child read of the heap memory (registered
// read) followed by a compare and write back of the hole.
// the output register lets a new input be accepted while a result waits;
// a stalled result holds, and a following operation waits in its final
// state until the output register is free.
// reset clears the counters and the control; handle map entries are made
// valid by writing zero for every request number not taken by an insert,
// so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key
    import ihd_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int MAX_HANDLES = MAX_HANDLES_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    localparam int SB = $clog2(CAPACITY + 1),
    localparam int HB = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1,
    localparam int RB = $clog2(MAX_HANDLES + 1),
    localparam int VB = VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic signed [VB-1:0] value,
    input  logic [HB-1:0]        handle,
    input  logic [VB-2:0]        delta,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic signed [VB-1:0] min_value,
    output logic [SB-1:0]        count,
    output logic [HB-1:0]        assigned_handle
);

    localparam int EW = VB + HB;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DK_SLOT = 11'b000_0000_0010,
        S_DK_VAL  = 11'b000_0000_0100,
        S_UP_RD   = 11'b000_0000_1000,
        S_UP_CMP  = 11'b000_0001_0000,
        S_EX_ROOT = 11'b000_0010_0000,
        S_EX_LAST = 11'b000_0100_0000,
        S_DN_RL   = 11'b000_1000_0000,
        S_DN_RR   = 11'b001_0000_0000,
        S_DN_CMP  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SB-1:0]        cnt_reg, cnt_next;
    logic [RB-1:0]        rn_reg, rn_next;
    logic [SB-1:0]        s_reg, s_next;
    logic signed [VB-1:0] cur_v_reg, cur_v_next;
    logic [HB-1:0]        cur_h_reg, cur_h_next;
    logic [VB-2:0]        delta_reg, delta_next;
    logic [1:0]           st_reg, st_next;
    logic [HB-1:0]        asg_reg, asg_next;
    logic signed [VB-1:0] min_reg, min_next;
    logic [EW-1:0]        left_reg, left_next;
    logic                 r_ok_reg, r_ok_next;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic signed [VB-1:0] out_min_reg;
    logic [SB-1:0]        out_count_reg;
    logic [HB-1:0]        out_asg_reg;

    // heap memory: {value, handle} per slot
    logic          h_we;
    logic [SB-1:0] h_waddr, h_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    // handle to slot map
    logic          m_we;
    logic [HB-1:0] m_waddr, m_raddr;
    logic [SB-1:0] m_wdata, m_rdata;

    ihd_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    ihd_ram #(.WIDTH(SB), .DEPTH(MAX_HANDLES)) u_map_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    logic                 accept;
    logic                 out_load;
    logic [RB-1:0]        rn_inc;
    logic                 rn_in_range;
    logic signed [VB-1:0] rd_v, left_v, pick_v;
    logic [HB-1:0]        rd_h, pick_h;
    logic [SB:0]          l_slot, r_slot;
    logic                 pick_right;
    logic signed [VB:0]   diff;
    logic signed [VB-1:0] dec_v;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign rn_inc      = (rn_reg < RB'(MAX_HANDLES)) ? RB'(rn_reg + 1'b1) : rn_reg;
    assign rn_in_range = (rn_inc < RB'(MAX_HANDLES));

    assign rd_v   = h_rdata[EW-1:HB];
    assign rd_h   = h_rdata[HB-1:0];
    assign left_v = left_reg[EW-1:HB];

    assign l_slot = {s_reg, 1'b0};
    assign r_slot = {s_reg, 1'b1};

    // right child wins only when strictly smaller than the left
    assign pick_right = r_ok_reg && (rd_v < left_v);
    assign pick_v     = pick_right ? rd_v : left_v;
    assign pick_h     = pick_right ? rd_h : left_reg[HB-1:0];

    // saturating decrease
    assign diff  = $signed({rd_v[VB-1], rd_v}) - $signed({2'b00, delta_reg});
    assign dec_v = (diff[VB] != diff[VB-1]) ? {1'b1, {(VB-1){1'b0}}} : diff[VB-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rn_next    = rn_reg;
        s_next     = s_reg;
        cur_v_next = cur_v_reg;
        cur_h_next = cur_h_reg;
        delta_next = delta_reg;
        st_next    = st_reg;
        asg_next   = asg_reg;
        left_next  = left_reg;
        r_ok_next  = r_ok_reg;
        h_we       = 1'b0;
        h_waddr    = s_reg;
        h_wdata    = {cur_v_reg, cur_h_reg};
        h_raddr    = s_reg;
        m_we       = 1'b0;
        m_waddr    = cur_h_reg;
        m_wdata    = s_reg;
        m_raddr    = handle;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rn_next    = rn_inc;
                    delta_next = delta;
                    st_next    = ST_OK;
                    asg_next   = '0;
                    state_next = S_DONE;
                    // request numbers not taken by an insert map to no slot
                    if (!(op == OP_INSERT && rn_in_range && cnt_reg < SB'(CAPACITY))
                        && rn_in_range)
                    begin
                        m_we    = 1'b1;
                        m_waddr = rn_inc[HB-1:0];
                        m_wdata = '0;
                    end
                    case (op)
                        OP_INSERT:
                        begin
                            if (!rn_in_range || cnt_reg >= SB'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                cnt_next   = SB'(cnt_reg + 1'b1);
                                s_next     = SB'(cnt_reg + 1'b1);
                                cur_v_next = value;
                                cur_h_next = rn_inc[HB-1:0];
                                asg_next   = rn_inc[HB-1:0];
                                state_next = S_UP_RD;
                            end
                        end
                        OP_GET_MIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                h_raddr    = SB'(1);
                                state_next = S_EX_ROOT;
                            end
                        end
                        default:
                        begin
                            if (handle == '0 || RB'(handle) >= rn_inc)
                            begin
                                st_next = ST_STALE;
                            end
                            else
                            begin
                                m_raddr    = handle;
                                state_next = S_DK_SLOT;
                            end
                        end
                    endcase
                end
            end
            S_DK_SLOT:
            begin
                if (m_rdata == '0 || m_rdata > cnt_reg)
                begin
                    st_next    = ST_STALE;
                    state_next = S_DONE;
                end
                else
                begin
                    s_next     = m_rdata;
                    h_raddr    = m_rdata;
                    state_next = S_DK_VAL;
                end
            end
            S_DK_VAL:
            begin
                cur_v_next = dec_v;
                cur_h_next = rd_h;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (s_reg == SB'(1))
                begin
                    h_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    h_raddr    = s_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (cur_v_reg < rd_v)
                begin
                    // parent moves down into the hole
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    m_we       = 1'b1;
                    m_waddr    = rd_h;
                    s_next     = s_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    h_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_EX_ROOT:
            begin
                m_we       = 1'b1;
                m_waddr    = rd_h;
                m_wdata    = '0;
                h_raddr    = cnt_reg;
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                cur_v_next = rd_v;
                cur_h_next = rd_h;
                cnt_next   = SB'(cnt_reg - 1'b1);
                s_next     = SB'(1);
                state_next = (cnt_reg == SB'(1)) ? S_DONE : S_DN_RL;
            end
            S_DN_RL:
            begin
                if (l_slot > {1'b0, cnt_reg})
                begin
                    h_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    h_raddr    = l_slot[SB-1:0];
                    state_next = S_DN_RR;
                end
            end
            S_DN_RR:
            begin
                left_next  = h_rdata;
                r_ok_next  = (r_slot <= {1'b0, cnt_reg});
                h_raddr    = r_slot[SB-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (pick_v < cur_v_reg)
                begin
                    // smaller child moves up into the hole
                    h_we       = 1'b1;
                    h_wdata    = {pick_v, pick_h};
                    m_we       = 1'b1;
                    m_waddr    = pick_h;
                    s_next     = pick_right ? r_slot[SB-1:0] : l_slot[SB-1:0];
                    state_next = S_DN_RL;
                end
                else
                begin
                    h_we       = 1'b1;
                    m_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root copy kept beside the memory
    assign min_next = (h_we && h_waddr == SB'(1)) ? h_wdata[EW-1:HB] : min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rn_reg    <= rn_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        cur_v_reg <= cur_v_next;
        cur_h_reg <= cur_h_next;
        delta_reg <= delta_next;
        st_reg    <= st_next;
        asg_reg   <= asg_next;
        min_reg   <= min_next;
        left_reg  <= left_next;
        r_ok_reg  <= r_ok_next;
        if (out_load)
        begin
            out_status_reg <= st_reg;
            out_min_reg    <= (cnt_reg != '0) ? min_reg : '0;
            out_count_reg  <= cnt_reg;
            out_asg_reg    <= asg_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign min_value       = out_min_reg;
    assign count           = out_count_reg;
    assign assigned_handle = out_asg_reg;

endmodule

>>> hw/rtl/ihd_ram.sv
// ----------------------------------------------------------------------------
// ihd_ram
// simple dual-port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
module ihd_ram
    import ihd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ihd_checker.sv
// ----------------------------------------------------------------------------
// ihd_checker
// port-level checks on the result channel of the indexed min-heap
// ----------------------------------------------------------------------------
module ihd_checker
    import ihd_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int MAX_HANDLES = MAX_HANDLES_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    localparam int SB = $clog2(CAPACITY + 1),
    localparam int HB = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1,
    localparam int VB = VALUE_BITS
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           status,
    input logic signed [VB-1:0] min_value,
    input logic [SB-1:0]        count,
    input logic [HB-1:0]        assigned_handle
);

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
        && $stable(min_value) && $stable(assigned_handle))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= SB'(CAPACITY))
        else $error("count above capacity");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == '0 |-> min_value == '0)
        else $error("empty heap with nonzero minimum");

    a_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned_handle != '0 |-> status == ST_OK && count != '0)
        else $error("handle given on a failed insert");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with entries present");

endmodule

bind indexed_min_heap_decrease_key ihd_checker #(
    .CAPACITY    (CAPACITY),
    .MAX_HANDLES (MAX_HANDLES),
    .VALUE_BITS  (VALUE_BITS)
) u_ihd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .min_value       (min_value),
    .count           (count),
    .assigned_handle (assigned_handle)
);
